// ----- rtl/quaternion_vector_rotation_unit_defines.svh -----
// Assertion macros used by the checker file of the quaternion vector rotation unit.
`ifndef QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH
`define QUATERNION_VECTOR_ROTATION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QVR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr checker: implication failed");

// Next-cycle implication, disabled while reset is high.
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr checker: next-cycle implication failed");

`endif

// ----- rtl/qvr_pkg.sv -----
// Package with widths, payload types and rounding helpers of the rotation unit.
`timescale 1ns / 1ps
`default_nettype none

package qvr_pkg;

  // Fixed point formats of the fields.
  localparam int FRAC_BITS = 14;
  localparam int QUAT_W    = 16;
  localparam int SAMPLE_W  = 16;

  // First Hamilton product: three products per component.
  localparam int PROD1_W = QUAT_W + SAMPLE_W;
  localparam int SUM1_W  = PROD1_W + 2;
  localparam int U_W     = SUM1_W - FRAC_BITS;

  // Second Hamilton product: four products per component.
  localparam int PROD2_W = U_W + QUAT_W;
  localparam int SUM2_W  = PROD2_W + 2;
  localparam int R_W     = SUM2_W - FRAC_BITS;

  typedef logic signed [QUAT_W-1:0]   quat_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD1_W-1:0]  prod1_t;
  typedef logic signed [SUM1_W-1:0]   sum1_t;
  typedef logic signed [U_W-1:0]      u_t;
  typedef logic signed [PROD2_W-1:0]  prod2_t;
  typedef logic signed [SUM2_W-1:0]   sum2_t;
  typedef logic signed [R_W-1:0]      r_t;

  typedef struct packed {
    quat_t   quat_w;
    quat_t   quat_x;
    quat_t   quat_y;
    quat_t   quat_z;
    sample_t vec_x;
    sample_t vec_y;
    sample_t vec_z;
  } qvr_in_t;

  typedef struct packed {
    sample_t rot_x;
    sample_t rot_y;
    sample_t rot_z;
    logic    saturated;
  } qvr_out_t;

  // Intermediate quaternion u = q * (0, v) together with q.
  typedef struct packed {
    u_t    u_w;
    u_t    u_x;
    u_t    u_y;
    u_t    u_z;
    quat_t q_w;
    quat_t q_x;
    quat_t q_y;
    quat_t q_z;
  } qvr_mid_t;

  // Round to nearest with ties toward plus infinity, then drop the fraction.
  function automatic u_t round_u(input sum1_t s);
    sum1_t half;
    sum1_t t;
    half = '0;
    half[FRAC_BITS-1] = 1'b1;
    t = s + half;
    return t[SUM1_W-1:FRAC_BITS];
  endfunction

  function automatic r_t round_r(input sum2_t s);
    sum2_t half;
    sum2_t t;
    half = '0;
    half[FRAC_BITS-1] = 1'b1;
    t = s + half;
    return t[SUM2_W-1:FRAC_BITS];
  endfunction

  // Clip to the sample range; the top bit of the result is the clip flag.
  function automatic logic [SAMPLE_W:0] clip_sample(input r_t v);
    logic fits;
    fits = (v[R_W-1:SAMPLE_W-1] == '0) || (v[R_W-1:SAMPLE_W-1] == '1);
    if (fits) begin
      return {1'b0, v[SAMPLE_W-1:0]};
    end else if (v[R_W-1]) begin
      return {1'b1, 1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b1, 1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/quaternion_vector_rotation_unit.sv -----
// Top level of the quaternion vector rotation unit.
//
// Usage:
//   The item channel (item_valid, item_stall, item) carries a quaternion q in
//   signed Q2.14 and a 3-vector v of signed 16-bit samples. The result channel
//   (result_valid, result_stall, result) returns the vector part of
//   q * (0, v) * conj(q), rounded to nearest and clipped to 16 bits, with a
//   flag that is set when any component was clipped.
//   A transaction completes on a rising edge where valid is high and stall is
//   low. The datapath has four register stages (two per Hamilton product). The
//   edge that takes an item loads the first stage, and its result is offered
//   from stage D once the item has passed through stages A, B and C.
//   One item per cycle is accepted for as long as the receiver keeps up.
//   Each stage loads whenever it is empty or its content moves on, so empty
//   slots close up while the receiver stalls; the input stalls only once all
//   four stages hold items. No transaction is lost or repeated.
//   Reset clears every stage valid bit; in-flight items are dropped.
//   The block holds no state between items and has no configuration.
`timescale 1ns / 1ps
`default_nettype none

module quaternion_vector_rotation_unit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire qvr_pkg::qvr_in_t item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output qvr_pkg::qvr_out_t     result
);

  logic              mid_valid;
  logic              mid_stall;
  qvr_pkg::qvr_mid_t mid;

  // u = q * (0, v)
  qvr_first_product u_first (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .mid_valid  (mid_valid),
    .mid_stall  (mid_stall),
    .mid        (mid)
  );

  // Vector part of u * conj(q)
  qvr_second_product u_second (
    .clk          (clk),
    .rst          (rst),
    .mid_valid    (mid_valid),
    .mid_stall    (mid_stall),
    .mid          (mid),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ----- rtl/qvr_first_product.sv -----
// Two pipeline stages that compute u = q * (0, v) with rounding.
`timescale 1ns / 1ps
`default_nettype none

module qvr_first_product (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire qvr_pkg::qvr_in_t item,
  output logic                  mid_valid,
  input  wire logic             mid_stall,
  output qvr_pkg::qvr_mid_t     mid
);

  logic                  a_valid;
  qvr_pkg::prod1_t       a_prod [12];
  qvr_pkg::quat_t        a_qw;
  qvr_pkg::quat_t        a_qx;
  qvr_pkg::quat_t        a_qy;
  qvr_pkg::quat_t        a_qz;
  logic                  b_valid;
  qvr_pkg::qvr_mid_t     b_data;
  logic                  en_a;
  logic                  en_b;
  qvr_pkg::sum1_t        sum_w;
  qvr_pkg::sum1_t        sum_x;
  qvr_pkg::sum1_t        sum_y;
  qvr_pkg::sum1_t        sum_z;

  // A stage loads when it is empty or its content moves on.
  assign en_b       = !b_valid || !mid_stall;
  assign en_a       = !a_valid || en_b;
  assign item_stall = !en_a;

  // Stage A: the twelve products of q and v.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en_a) begin
      a_valid <= item_valid;
    end
    if (en_a) begin
      a_prod[0]  <= item.quat_x * item.vec_x;
      a_prod[1]  <= item.quat_y * item.vec_y;
      a_prod[2]  <= item.quat_z * item.vec_z;
      a_prod[3]  <= item.quat_w * item.vec_x;
      a_prod[4]  <= item.quat_y * item.vec_z;
      a_prod[5]  <= item.quat_z * item.vec_y;
      a_prod[6]  <= item.quat_w * item.vec_y;
      a_prod[7]  <= item.quat_z * item.vec_x;
      a_prod[8]  <= item.quat_x * item.vec_z;
      a_prod[9]  <= item.quat_w * item.vec_z;
      a_prod[10] <= item.quat_x * item.vec_y;
      a_prod[11] <= item.quat_y * item.vec_x;
      a_qw       <= item.quat_w;
      a_qx       <= item.quat_x;
      a_qy       <= item.quat_y;
      a_qz       <= item.quat_z;
    end
  end

  // Component sums of the Hamilton product with a zero scalar part.
  always_comb begin
    sum_w = -(qvr_pkg::sum1_t'(a_prod[0]) + qvr_pkg::sum1_t'(a_prod[1])
              + qvr_pkg::sum1_t'(a_prod[2]));
    sum_x = qvr_pkg::sum1_t'(a_prod[3]) + qvr_pkg::sum1_t'(a_prod[4])
            - qvr_pkg::sum1_t'(a_prod[5]);
    sum_y = qvr_pkg::sum1_t'(a_prod[6]) + qvr_pkg::sum1_t'(a_prod[7])
            - qvr_pkg::sum1_t'(a_prod[8]);
    sum_z = qvr_pkg::sum1_t'(a_prod[9]) + qvr_pkg::sum1_t'(a_prod[10])
            - qvr_pkg::sum1_t'(a_prod[11]);
  end

  // Stage B: rounded u. Its range fits well inside the 20-bit u_t, so no clip is needed.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
    if (en_b) begin
      b_data.u_w <= qvr_pkg::round_u(sum_w);
      b_data.u_x <= qvr_pkg::round_u(sum_x);
      b_data.u_y <= qvr_pkg::round_u(sum_y);
      b_data.u_z <= qvr_pkg::round_u(sum_z);
      b_data.q_w <= a_qw;
      b_data.q_x <= a_qx;
      b_data.q_y <= a_qy;
      b_data.q_z <= a_qz;
    end
  end

  assign mid_valid = b_valid;
  assign mid       = b_data;

endmodule

`default_nettype wire

// ----- rtl/qvr_second_product.sv -----
// Two pipeline stages that compute the vector part of u * conj(q), rounded and clipped.
`timescale 1ns / 1ps
`default_nettype none

module qvr_second_product (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              mid_valid,
  output logic                   mid_stall,
  input  wire qvr_pkg::qvr_mid_t mid,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output qvr_pkg::qvr_out_t      result
);

  logic                        c_valid;
  qvr_pkg::prod2_t             c_prod [12];
  logic                        d_valid;
  qvr_pkg::qvr_out_t           d_data;
  logic                        en_c;
  logic                        en_d;
  qvr_pkg::sum2_t              sum_x;
  qvr_pkg::sum2_t              sum_y;
  qvr_pkg::sum2_t              sum_z;
  logic [qvr_pkg::SAMPLE_W:0]  clip_x;
  logic [qvr_pkg::SAMPLE_W:0]  clip_y;
  logic [qvr_pkg::SAMPLE_W:0]  clip_z;

  // The output register frees up when the receiver takes its transaction.
  assign en_d      = !d_valid || !result_stall;
  assign en_c      = !c_valid || en_d;
  assign mid_stall = !en_c;

  // Stage C: the twelve products of u and q.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en_c) begin
      c_valid <= mid_valid;
    end
    if (en_c) begin
      c_prod[0]  <= mid.u_w * mid.q_x;
      c_prod[1]  <= mid.q_w * mid.u_x;
      c_prod[2]  <= mid.u_y * mid.q_z;
      c_prod[3]  <= mid.u_z * mid.q_y;
      c_prod[4]  <= mid.u_w * mid.q_y;
      c_prod[5]  <= mid.q_w * mid.u_y;
      c_prod[6]  <= mid.u_z * mid.q_x;
      c_prod[7]  <= mid.u_x * mid.q_z;
      c_prod[8]  <= mid.u_w * mid.q_z;
      c_prod[9]  <= mid.q_w * mid.u_z;
      c_prod[10] <= mid.u_x * mid.q_y;
      c_prod[11] <= mid.u_y * mid.q_x;
    end
  end

  // Vector part of the product with the conjugate, then round and clip.
  always_comb begin
    sum_x = -qvr_pkg::sum2_t'(c_prod[0]) + qvr_pkg::sum2_t'(c_prod[1])
            - qvr_pkg::sum2_t'(c_prod[2]) + qvr_pkg::sum2_t'(c_prod[3]);
    sum_y = -qvr_pkg::sum2_t'(c_prod[4]) + qvr_pkg::sum2_t'(c_prod[5])
            - qvr_pkg::sum2_t'(c_prod[6]) + qvr_pkg::sum2_t'(c_prod[7]);
    sum_z = -qvr_pkg::sum2_t'(c_prod[8]) + qvr_pkg::sum2_t'(c_prod[9])
            - qvr_pkg::sum2_t'(c_prod[10]) + qvr_pkg::sum2_t'(c_prod[11]);
    clip_x = qvr_pkg::clip_sample(qvr_pkg::round_r(sum_x));
    clip_y = qvr_pkg::clip_sample(qvr_pkg::round_r(sum_y));
    clip_z = qvr_pkg::clip_sample(qvr_pkg::round_r(sum_z));
  end

  // Stage D: output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en_d) begin
      d_valid <= c_valid;
    end
    if (en_d) begin
      d_data.rot_x     <= clip_x[qvr_pkg::SAMPLE_W-1:0];
      d_data.rot_y     <= clip_y[qvr_pkg::SAMPLE_W-1:0];
      d_data.rot_z     <= clip_z[qvr_pkg::SAMPLE_W-1:0];
      d_data.saturated <= clip_x[qvr_pkg::SAMPLE_W] | clip_y[qvr_pkg::SAMPLE_W]
                          | clip_z[qvr_pkg::SAMPLE_W];
    end
  end

  assign result_valid = d_valid;
  assign result       = d_data;

endmodule

`default_nettype wire

// ----- rtl/qvr_checker.sv -----
// Port-level checker for the quaternion vector rotation unit, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "quaternion_vector_rotation_unit_defines.svh"

module qvr_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_stall,
  input wire qvr_pkg::qvr_in_t  item,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire qvr_pkg::qvr_out_t result
);

  logic item_take;
  logic clipped_x;
  logic clipped_y;
  logic clipped_z;

  assign item_take = item_valid && !item_stall;
  assign clipped_x = (result.rot_x == 16'h7fff) || (result.rot_x == 16'h8000);
  assign clipped_y = (result.rot_y == 16'h7fff) || (result.rot_y == 16'h8000);
  assign clipped_z = (result.rot_z == 16'h7fff) || (result.rot_z == 16'h8000);

  // A stalled item transaction stays put.
  `QVR_ASSERT_NEXT(a_item_hold, clk, rst, item_valid && item_stall,
                   item_valid && $stable(item))

  // A stalled result transaction stays put.
  `QVR_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall,
                   result_valid && $stable(result))

  // With no stall and no reset, a taken item shows up at the result after passing through the pipeline.
  `QVR_ASSERT_IMPLY(a_latency, clk, rst,
                    $past(item_take, 4) && !$past(rst, 4) && !$past(rst, 3)
                    && !$past(rst, 2) && !$past(rst, 1) && !$past(result_stall, 3)
                    && !$past(result_stall, 2) && !$past(result_stall, 1),
                    result_valid)

  // The clip flag only comes with a component at a range limit.
  `QVR_ASSERT_IMPLY(a_flag_limit, clk, rst, result_valid && result.saturated,
                    clipped_x || clipped_y || clipped_z)

  // Right after reset the result channel is empty.
  `QVR_ASSERT_IMPLY(a_reset_empty, clk, rst, $fell(rst), !result_valid)

endmodule

bind quaternion_vector_rotation_unit qvr_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/quaternion_vector_rotation_unit_test.sv -----
// Self-checking testbench for the quaternion vector rotation unit.
`timescale 1ns / 1ps

module quaternion_vector_rotation_unit_test;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 12;
  localparam int REPORT_LIMIT  = 10;
  localparam int Q_ONE         = 1 << qvr_pkg::FRAC_BITS;
  localparam int Q_HALF_ROOT2  = 11585;
  localparam int Q_ROOT2       = 23170;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_PATTERN
  } stall_mode_t;

  logic              clk;
  logic              rst;
  logic              item_valid;
  logic              item_stall;
  qvr_pkg::qvr_in_t  item;
  logic              result_valid;
  logic              result_stall;
  qvr_pkg::qvr_out_t result;

  // Rotations predicted for accepted transactions, oldest first.
  qvr_pkg::qvr_out_t pending_rotations[$];
  stall_mode_t       stall_mode;
  logic              send_gaps;
  int                burst_left;
  int                hold_cycles;
  int                pattern_idx;
  int                cycle_count;
  int                items_sent;
  int                directed_sent;
  int                results_checked;
  int                clipped_results;
  int                input_stall_cycles;
  int                fail_count;

  quaternion_vector_rotation_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always #CLK_HALF clk = ~clk;

  // Round to nearest with ties toward plus infinity, then drop the fraction.
  function automatic longint round_frac(input longint s);
    return (s + (longint'(1) <<< (qvr_pkg::FRAC_BITS - 1))) >>> qvr_pkg::FRAC_BITS;
  endfunction

  // Clip to a signed range of the given width and report whether it clipped.
  function automatic longint clip_signed(input longint v, input int w, output logic hit);
    longint hi;
    longint lo;
    hi  = (longint'(1) <<< (w - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Vector part of q * (0, v) * conj(q) in fixed point.
  function automatic qvr_pkg::qvr_out_t rotate_vector(input qvr_pkg::qvr_in_t t);
    longint            qw, qx, qy, qz, vx, vy, vz;
    longint            uw, ux, uy, uz, rx, ry, rz;
    logic              hit;
    logic              sat;
    qvr_pkg::qvr_out_t r;
    qw = t.quat_w;
    qx = t.quat_x;
    qy = t.quat_y;
    qz = t.quat_z;
    vx = t.vec_x;
    vy = t.vec_y;
    vz = t.vec_z;
    sat = 1'b0;

    // First Hamilton product with the pure quaternion of the vector.
    uw = clip_signed(round_frac(-(qx * vx + qy * vy + qz * vz)), 32, hit);
    sat |= hit;
    ux = clip_signed(round_frac(qw * vx + (qy * vz - qz * vy)), 32, hit);
    sat |= hit;
    uy = clip_signed(round_frac(qw * vy + (qz * vx - qx * vz)), 32, hit);
    sat |= hit;
    uz = clip_signed(round_frac(qw * vz + (qx * vy - qy * vx)), 32, hit);
    sat |= hit;

    // Second product with the conjugate; only the vector part is kept.
    rx = clip_signed(round_frac(-uw * qx + qw * ux + (-uy * qz + uz * qy)),
                     qvr_pkg::SAMPLE_W, hit);
    sat |= hit;
    ry = clip_signed(round_frac(-uw * qy + qw * uy + (-uz * qx + ux * qz)),
                     qvr_pkg::SAMPLE_W, hit);
    sat |= hit;
    rz = clip_signed(round_frac(-uw * qz + qw * uz + (-ux * qy + uy * qx)),
                     qvr_pkg::SAMPLE_W, hit);
    sat |= hit;

    r.rot_x     = qvr_pkg::sample_t'(rx);
    r.rot_y     = qvr_pkg::sample_t'(ry);
    r.rot_z     = qvr_pkg::sample_t'(rz);
    r.saturated = sat;
    return r;
  endfunction

  function automatic qvr_pkg::qvr_in_t make_item(input int w, input int x, input int y,
                                                 input int z, input int vx, input int vy,
                                                 input int vz);
    qvr_pkg::qvr_in_t t;
    t.quat_w = qvr_pkg::quat_t'(w);
    t.quat_x = qvr_pkg::quat_t'(x);
    t.quat_y = qvr_pkg::quat_t'(y);
    t.quat_z = qvr_pkg::quat_t'(z);
    t.vec_x  = qvr_pkg::sample_t'(vx);
    t.vec_y  = qvr_pkg::sample_t'(vy);
    t.vec_z  = qvr_pkg::sample_t'(vz);
    return t;
  endfunction

  // Offer one transaction and hold it until it is taken; gaps fall between bursts.
  task automatic send_rotation(input qvr_pkg::qvr_in_t t);
    int gap;
    if (send_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        item_valid <= 1'b0;
      end
    end
    @(negedge clk);
    item_valid <= 1'b1;
    item       <= t;
    do @(posedge clk); while (item_stall);
    if (burst_left > 0) burst_left--;
    items_sent++;
  endtask

  // Lower the input and wait for every outstanding rotation to come back.
  task automatic wait_for_results();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending_rotations.size() != 0) @(posedge clk);
  endtask

  function automatic int signed_range(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Mostly quaternions of norm up to one with random vectors, some full-range noise, some small vectors.
  function automatic qvr_pkg::qvr_in_t random_rotation();
    int kind;
    kind = $urandom_range(0, 9);
    if (kind <= 5) begin
      return make_item(signed_range(Q_ONE / 2), signed_range(Q_ONE / 2),
                       signed_range(Q_ONE / 2), signed_range(Q_ONE / 2),
                       $urandom, $urandom, $urandom);
    end else if (kind <= 7) begin
      return make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    return make_item(signed_range(Q_ONE / 2), signed_range(Q_ONE / 2),
                     signed_range(Q_ONE / 2), signed_range(Q_ONE / 2),
                     signed_range(64), signed_range(64), signed_range(64));
  endfunction

  // Axis rotations, identities, extremes, norm scaling and rounding ties.
  task automatic test_directed();
    send_gaps  = 1'b1;
    stall_mode = STALL_RANDOM;
    send_rotation(make_item(0, 0, 0, 0, 32767, -32768, 1));
    send_rotation(make_item(Q_ONE, 0, 0, 0, 32767, -32768, -1));
    send_rotation(make_item(Q_ONE, 0, 0, 0, 1, 2, 3));
    send_rotation(make_item(-Q_ONE, 0, 0, 0, 5, -5, 7));
    send_rotation(make_item(Q_HALF_ROOT2, 0, 0, Q_HALF_ROOT2, 1000, 0, 0));
    send_rotation(make_item(Q_HALF_ROOT2, Q_HALF_ROOT2, 0, 0, 0, 1000, 0));
    send_rotation(make_item(Q_HALF_ROOT2, 0, Q_HALF_ROOT2, 0, 0, 0, 1000));
    send_rotation(make_item(0, Q_ONE, 0, 0, 100, 200, 300));
    send_rotation(make_item(0, 0, 0, Q_ONE, 32767, 32767, 32767));
    send_rotation(make_item(Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, Q_ONE / 2, 100, 0, 0));
    send_rotation(make_item(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_rotation(make_item(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_rotation(make_item(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    send_rotation(make_item(-1, -1, -1, -1, -1, -1, -1));
    send_rotation(make_item(1, 0, 0, 0, 1, 1, 1));
    // A non-unit quaternion scales by its squared norm; the second one clips.
    send_rotation(make_item(Q_ROOT2, 0, 0, 0, 1000, -1000, 10000));
    send_rotation(make_item(Q_ROOT2, 0, 0, 0, 20000, -20000, 0));
    send_rotation(make_item(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1000, 2000, 3000));
    // Half-way sums in the first product round toward plus infinity.
    send_rotation(make_item(Q_ONE / 2, 0, 0, 0, 1, -1, 0));
    send_rotation(make_item(Q_ONE / 2, 0, 0, 0, 3, -3, 1));
    directed_sent = items_sent;
    wait_for_results();
  endtask

  task automatic test_random_rotations(input int count, input stall_mode_t mode);
    send_gaps  = 1'b1;
    stall_mode = mode;
    repeat (count) send_rotation(random_rotation());
    wait_for_results();
  endtask

  // Back-to-back transactions with neither side idling.
  task automatic test_streaming(input int count);
    send_gaps  = 1'b0;
    stall_mode = STALL_NONE;
    repeat (count) send_rotation(random_rotation());
    wait_for_results();
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_receiver_hold(input int count);
    send_gaps   = 1'b0;
    stall_mode  = STALL_NONE;
    hold_cycles = 80;
    repeat (count) send_rotation(random_rotation());
    wait_for_results();
  endtask

  // Receiver stall pattern, driven at the falling edge.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_stall <= 1'b1;
      hold_cycles--;
    end else begin
      case (stall_mode)
        STALL_NONE: begin
          result_stall <= 1'b0;
        end
        STALL_RANDOM: begin
          result_stall <= ($urandom_range(0, 99) < 35);
        end
        default: begin
          result_stall <= (pattern_idx % 7 == 2) || (pattern_idx % 11 < 3);
        end
      endcase
      pattern_idx++;
    end
  end

  // Record accepted items and check each accepted result against the oldest prediction.
  always @(posedge clk) begin : check_results
    qvr_pkg::qvr_out_t want;
    if (!rst) begin
      if (item_valid && item_stall) input_stall_cycles++;
      if (item_valid && !item_stall) pending_rotations.push_back(rotate_vector(item));
      if (result_valid && !result_stall) begin
        if (pending_rotations.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("unexpected result: rot=(%0d, %0d, %0d) sat=%0b",
                     result.rot_x, result.rot_y, result.rot_z, result.saturated);
        end else begin
          want = pending_rotations.pop_front();
          results_checked++;
          if (result.saturated) clipped_results++;
          if (result.rot_x !== want.rot_x || result.rot_y !== want.rot_y ||
              result.rot_z !== want.rot_z || result.saturated !== want.saturated) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
              $display({"mismatch on result %0d: expected (%0d, %0d, %0d) sat=%0b, ",
                        "got (%0d, %0d, %0d) sat=%0b"},
                       results_checked, want.rot_x, want.rot_y, want.rot_z, want.saturated,
                       result.rot_x, result.rot_y, result.rot_z, result.saturated);
          end
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_rotations.size());
      $display("quaternion_vector_rotation_unit regression: fail");
      $finish;
    end
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    item_valid         = 1'b0;
    item               = '0;
    result_stall       = 1'b0;
    stall_mode         = STALL_NONE;
    send_gaps          = 1'b0;
    burst_left         = 0;
    hold_cycles        = 0;
    pattern_idx        = 0;
    cycle_count        = 0;
    items_sent         = 0;
    directed_sent      = 0;
    results_checked    = 0;
    clipped_results    = 0;
    input_stall_cycles = 0;
    fail_count         = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_rotations(300, STALL_RANDOM);
    test_receiver_hold(60);
    test_random_rotations(200, STALL_PATTERN);
    test_streaming(150);
    test_random_rotations(150, STALL_RANDOM);

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d rotations (%0d directed); %0d results checked, %0d of them clipped.",
             items_sent, directed_sent, results_checked, clipped_results);
    $display("Input was held off on %0d cycles; %0d failures.", input_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("quaternion_vector_rotation_unit regression: pass");
    end else begin
      $display("quaternion_vector_rotation_unit regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/qvr_pkg.sv
rtl/qvr_first_product.sv
rtl/qvr_second_product.sv
rtl/quaternion_vector_rotation_unit.sv
rtl/qvr_checker.sv
tb/sv/quaternion_vector_rotation_unit_test.sv
